/* design/quaternion_attitude_integrator_assert.svh */
// ----------------------------------------------------------------------------
// quaternion attitude integrator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
`define QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QAI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion integrator check failed");
`define QAI_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion integrator check failed");
`else
`define QAI_ASSERT_IMP(name, ante, cons)
`define QAI_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* design/qai_pkg.sv */
// ----------------------------------------------------------------------------
// qai_pkg
// widths, register map, control structs and the rate term table
// ----------------------------------------------------------------------------
package qai_pkg;

  localparam int RATE_W     = 24;
  localparam int W_W        = 25;
  localparam int STEP_W     = 24;
  localparam int Q_W        = 32;
  localparam int MOP_W      = 33;
  localparam int PROD_W     = 66;
  localparam int ACC_W      = 64;
  localparam int T_W        = 40;
  localparam int T_LO_W     = 20;
  localparam int P_W        = 42;
  localparam int M_W        = 31;
  localparam int K_W        = 4;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 35;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [STEP_W-1:0]   STEP_TIME_RST = 24'd167772;
  localparam logic signed [Q_W-1:0] ONE_Q30     = 32'sh4000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STEP_TIME,
    REG_BIAS_X,
    REG_BIAS_Y,
    REG_BIAS_Z,
    REG_START_W,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } qai_reg_t;

  // sequence steps within one quaternion component
  localparam logic [2:0] STEP_TERM_A = 3'd0;
  localparam logic [2:0] STEP_TERM_B = 3'd1;
  localparam logic [2:0] STEP_TERM_C = 3'd2;
  localparam logic [2:0] STEP_T_HI   = 3'd3;
  localparam logic [2:0] STEP_T_LO   = 3'd4;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic start;
    logic root;
  } qai_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } qai_stat_t;

  typedef struct packed {
    logic [1:0] wsel;
    logic [1:0] qsel;
    logic       neg;
  } qai_term_t;

  // rate axis, quaternion element and sign of each omega(w)*q term
  function automatic qai_term_t term_of(input logic [1:0] comp, input logic [2:0] step);
    qai_term_t t;
    t = '0;
    if (step == STEP_T_LO) begin
      t.qsel = comp;
    end else begin
      unique case ({comp, step})
        {2'd0, STEP_TERM_A}: t = qai_term_t'{AX_X, 2'd1, 1'b1};
        {2'd0, STEP_TERM_B}: t = qai_term_t'{AX_Y, 2'd2, 1'b1};
        {2'd0, STEP_TERM_C}: t = qai_term_t'{AX_Z, 2'd3, 1'b1};
        {2'd1, STEP_TERM_A}: t = qai_term_t'{AX_X, 2'd0, 1'b0};
        {2'd1, STEP_TERM_B}: t = qai_term_t'{AX_Z, 2'd2, 1'b0};
        {2'd1, STEP_TERM_C}: t = qai_term_t'{AX_Y, 2'd3, 1'b1};
        {2'd2, STEP_TERM_A}: t = qai_term_t'{AX_Y, 2'd0, 1'b0};
        {2'd2, STEP_TERM_B}: t = qai_term_t'{AX_Z, 2'd1, 1'b1};
        {2'd2, STEP_TERM_C}: t = qai_term_t'{AX_X, 2'd3, 1'b0};
        {2'd3, STEP_TERM_A}: t = qai_term_t'{AX_Z, 2'd0, 1'b0};
        {2'd3, STEP_TERM_B}: t = qai_term_t'{AX_Y, 2'd1, 1'b0};
        {2'd3, STEP_TERM_C}: t = qai_term_t'{AX_X, 2'd2, 1'b1};
        default:             t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

/* design/qai_rootdiv.sv */
// ----------------------------------------------------------------------------
// qai_rootdiv
// bit-serial square root and divider on one shared compare-subtract
// ----------------------------------------------------------------------------
`include "quaternion_attitude_integrator_assert.svh"

module qai_rootdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qai_pkg::qai_cmd_t             cmd,
  input  logic [qai_pkg::ACC_W-1:0]     radicand,
  input  logic [qai_pkg::M_W-1:0]       dividend,
  input  logic [qai_pkg::ROOT_W-1:0]    divisor,
  output qai_pkg::qai_stat_t            stat,
  output logic [qai_pkg::ROOT_W-1:0]    result
);
  import qai_pkg::*;

  localparam logic [CNT_W-1:0] ROOT_LAST = 5'd31;
  localparam logic [CNT_W-1:0] DIV_LAST  = 5'd30;

  logic              busy_r;
  logic              done_r;
  logic              root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] res_r;
  logic [ACC_W-1:0]  x_r;
  logic [ROOT_W-1:0] dvsr_r;

  logic [REM_W-1:0]  opa;
  logic [REM_W-1:0]  opb;
  logic [REM_W:0]    diff;
  logic              ge;

  // shared compare-subtract
  always_comb begin
    if (root_r) begin
      opa = {rem_r[32:0], x_r[63:62]};
      opb = {1'b0, res_r, 2'b01};
    end else begin
      opa = {2'b00, rem_r[31:0], x_r[63]};
      opb = {3'b000, dvsr_r};
    end
    diff = {1'b0, opa} - {1'b0, opb};
    ge   = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !cmd.start && (cnt_r == '0);
      if (cmd.start) begin
        busy_r <= 1'b1;
        root_r <= cmd.root;
        res_r  <= '0;
        dvsr_r <= divisor;
        if (cmd.root) begin
          cnt_r <= ROOT_LAST;
          rem_r <= '0;
          x_r   <= radicand;
        end else begin
          cnt_r <= DIV_LAST;
          rem_r <= {5'b00000, dividend[M_W-1:1]};
          x_r   <= {dividend[0], 63'b0};
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[REM_W-1:0] : opa;
        res_r <= {res_r[ROOT_W-2:0], ge};
        x_r   <= root_r ? {x_r[ACC_W-3:0], 2'b00} : {x_r[ACC_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = res_r;

  `QAI_ASSERT_IMP(a_no_restart, cmd.start, !busy_r)
  `QAI_ASSERT_IMP(a_done_after_last, done_r, $past(busy_r) && ($past(cnt_r) == '0))
  `QAI_ASSERT_IMP(a_root_rem_bound, busy_r && root_r, rem_r <= (35'(res_r) << 1))
  `QAI_ASSERT_IMP(a_div_rem_bound, busy_r && !root_r, rem_r < 35'(dvsr_r))

endmodule

/* design/quaternion_attitude_integrator.sv */
// ----------------------------------------------------------------------------
// quaternion attitude integrator: first-order update and renormalization
// one item at a time: in_tready stays low from accept until the result register loads
// in_tready returns on the same edge that loads the result register
// cost set by the bit-serial root and four 31-step divides on one compare-subtract
// rst_n synchronous: attitude to identity, registers to defaults, channels empty
// ----------------------------------------------------------------------------
`include "quaternion_attitude_integrator_assert.svh"

module quaternion_attitude_integrator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [qai_pkg::IN_DATA_W-1:0]     in_tdata,   // rate_x, rate_y, rate_z
  input  logic [qai_pkg::IN_USER_W-1:0]     in_tuser,   // mode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [qai_pkg::OUT_DATA_W-1:0]    out_tdata,  // quat_w, quat_x, quat_y, quat_z
  input  logic                              cfg_we,
  input  logic [qai_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [qai_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import qai_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_SCALE, S_ROOT, S_RWAIT, S_DIV, S_DWAIT, S_EMIT
  } state_t;

  localparam logic [1:0] COMP_LAST = 2'd3;

  // configuration
  logic [STEP_W-1:0]       step_r;
  logic [RATE_W-1:0]       bias_x_r, bias_y_r, bias_z_r;
  logic signed [Q_W-1:0]   start_w_r, start_x_r, start_y_r, start_z_r;

  state_t                  state_r;
  logic signed [Q_W-1:0]   q_r [4];
  logic signed [W_W-1:0]   w_r [3];
  logic [1:0]              c_r;
  logic [2:0]              u_r;
  logic                    sq_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [T_W-1:0]   t_r;
  logic [P_W-1:0]          mag_r [4];
  logic [3:0]              sgn_r;
  logic [P_W-1:0]          max_r;
  logic [M_W-1:0]          m_r [4];
  logic [ROOT_W-1:0]       n_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  qai_term_t               term;
  logic signed [W_W-1:0]   w_sel;
  logic signed [Q_W-1:0]   q_sel;
  logic signed [MOP_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod64;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [P_W-1:0]   p_nxt;
  logic [P_W-1:0]          mag_nxt;
  logic [K_W-1:0]          k;
  logic [M_W-1:0]          m_nxt [4];
  logic signed [Q_W-1:0]   quo;
  logic signed [Q_W-1:0]   q_div;

  qai_cmd_t                cmd;
  qai_stat_t               stat;
  logic [ROOT_W-1:0]       unit_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_TIME_RST;
      bias_x_r  <= '0;
      bias_y_r  <= '0;
      bias_z_r  <= '0;
      start_w_r <= ONE_Q30;
      start_x_r <= '0;
      start_y_r <= '0;
      start_z_r <= '0;
    end else if (cfg_we) begin
      unique case (qai_reg_t'(cfg_addr))
        REG_STEP_TIME: step_r    <= cfg_wdata[STEP_W-1:0];
        REG_BIAS_X:    bias_x_r  <= cfg_wdata[RATE_W-1:0];
        REG_BIAS_Y:    bias_y_r  <= cfg_wdata[RATE_W-1:0];
        REG_BIAS_Z:    bias_z_r  <= cfg_wdata[RATE_W-1:0];
        REG_START_W:   start_w_r <= cfg_wdata;
        REG_START_X:   start_x_r <= cfg_wdata;
        REG_START_Y:   start_y_r <= cfg_wdata;
        REG_START_Z:   start_z_r <= cfg_wdata;
        default:       step_r    <= step_r;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    term  = term_of(c_r, u_r);
    w_sel = w_r[term.wsel];
    q_sel = q_r[term.qsel];
    if (sq_r) begin
      mul_a = {2'b00, m_r[c_r]};
      mul_b = {2'b00, m_r[c_r]};
    end else begin
      case (u_r)
        STEP_T_HI: begin
          mul_a = {{13{t_r[T_W-1]}}, t_r[T_W-1:T_LO_W]};
          mul_b = {9'b0, step_r};
        end
        STEP_T_LO: begin
          mul_a = {13'b0, t_r[T_LO_W-1:0]};
          mul_b = {9'b0, step_r};
        end
        default: begin
          mul_a = {q_sel[Q_W-1], q_sel};
          mul_b = {{8{w_sel[W_W-1]}}, w_sel};
        end
      endcase
    end
    prod = mul_a * mul_b;
  end

  // accumulate, delta and new component
  always_comb begin
    prod64 = prod_r[ACC_W-1:0];
    if (sq_r) begin
      acc_nxt = acc_r + prod64;
    end else begin
      case (u_r)
        STEP_T_HI: acc_nxt = acc_r + (prod64 <<< T_LO_W);
        STEP_T_LO: acc_nxt = acc_r + prod64;
        default:   acc_nxt = term.neg ? acc_r - prod64 : acc_r + prod64;
      endcase
    end
    p_nxt   = {{10{q_sel[Q_W-1]}}, q_sel} + {acc_nxt[ACC_W-1], acc_nxt[ACC_W-1:23]};
    mag_nxt = p_nxt[P_W-1] ? P_W'(-p_nxt) : P_W'(p_nxt);
  end

  // normalizing shift from the largest magnitude
  always_comb begin
    k = '0;
    for (int i = M_W; i < P_W; i++) begin
      if (max_r[i]) k = K_W'(i - M_W + 1);
    end
    for (int j = 0; j < 4; j++) begin
      m_nxt[j] = M_W'(mag_r[j] >> k);
    end
  end

  assign quo   = unit_res;
  assign q_div = sgn_r[c_r] ? -quo : quo;

  assign cmd.start = (state_r == S_ROOT) || (state_r == S_DIV);
  assign cmd.root  = (state_r == S_ROOT);

  qai_rootdiv u_rootdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .radicand (acc_r),
    .dividend (m_r[c_r]),
    .divisor  (n_r),
    .stat     (stat),
    .result   (unit_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      q_r[0]       <= ONE_Q30;
      q_r[1]       <= '0;
      q_r[2]       <= '0;
      q_r[3]       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            w_r[0] <= {in_tdata[23], in_tdata[23:0]} - {bias_x_r[23], bias_x_r};
            w_r[1] <= {in_tdata[47], in_tdata[47:24]} - {bias_y_r[23], bias_y_r};
            w_r[2] <= {in_tdata[71], in_tdata[71:48]} - {bias_z_r[23], bias_z_r};
            c_r    <= '0;
            u_r    <= STEP_TERM_A;
            sq_r   <= 1'b0;
            acc_r  <= '0;
            max_r  <= '0;
            if (in_tuser[0]) begin
              q_r[0]  <= start_w_r;
              q_r[1]  <= start_x_r;
              q_r[2]  <= start_y_r;
              q_r[3]  <= start_z_r;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= prod;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (sq_r) begin
            acc_r <= acc_nxt;
            if (c_r == COMP_LAST) begin
              state_r <= S_ROOT;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_MUL;
            end
          end else if (u_r == STEP_TERM_C) begin
            t_r     <= acc_nxt[57:18];
            acc_r   <= '0;
            u_r     <= STEP_T_HI;
            state_r <= S_MUL;
          end else if (u_r == STEP_T_LO) begin
            acc_r      <= '0;
            mag_r[c_r] <= mag_nxt;
            sgn_r[c_r] <= p_nxt[P_W-1];
            if (mag_nxt > max_r) max_r <= mag_nxt;
            u_r <= STEP_TERM_A;
            if (c_r == COMP_LAST) begin
              state_r <= S_SCALE;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_MUL;
            end
          end else begin
            acc_r   <= acc_nxt;
            u_r     <= u_r + 3'd1;
            state_r <= S_MUL;
          end
        end
        S_SCALE: begin
          for (int j = 0; j < 4; j++) m_r[j] <= m_nxt[j];
          c_r     <= '0;
          sq_r    <= 1'b1;
          acc_r   <= '0;
          state_r <= S_MUL;
        end
        S_ROOT: begin
          state_r <= S_RWAIT;
        end
        S_RWAIT: begin
          if (stat.done) begin
            n_r     <= unit_res;
            c_r     <= '0;
            state_r <= (unit_res == '0) ? S_EMIT : S_DIV;
          end
        end
        S_DIV: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (stat.done) begin
            q_r[c_r] <= q_div;
            if (c_r == COMP_LAST) begin
              state_r <= S_EMIT;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_DIV;
            end
          end
        end
        S_EMIT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {q_r[3], q_r[2], q_r[1], q_r[0]};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `QAI_ASSERT_IMP(a_done_in_wait, stat.done, (state_r == S_RWAIT) || (state_r == S_DWAIT))
  `QAI_ASSERT_IMP(a_unit_free_on_div, state_r == S_DIV, !stat.busy)
  `QAI_ASSERT_IMP(a_norm_range, (state_r == S_DWAIT) && stat.done, (q_div <= ONE_Q30) && (q_div >= -ONE_Q30))
  `QAI_ASSERT_IMP(a_max_covers, state_r == S_SCALE, (max_r >= mag_r[0]) && (max_r >= mag_r[1]) && (max_r >= mag_r[2]) && (max_r >= mag_r[3]))
  `QAI_ASSERT_NXT(a_load_emits, in_tvalid && in_tready && in_tuser[0], state_r == S_EMIT)

endmodule

/* sim/quaternion_attitude_integrator_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion attitude integrator checker
// watches the register port and both stream channels, keeps its own copy of
// the registers and the attitude, predicts each result and compares it
// ----------------------------------------------------------------------------
module quaternion_attitude_integrator_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [qai_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [qai_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [qai_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [qai_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [qai_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import qai_pkg::*;

  // element 0 is the scalar part, in the lowest bits of out_tdata
  typedef logic [3:0][Q_W-1:0] quat_t;

  logic [STEP_W-1:0] step_len;
  logic [RATE_W-1:0] gyro_bias [3];
  quat_t             start_quat;
  quat_t             attitude;
  quat_t             expected_quats [$];
  quat_t             want;
  quat_t             got;
  string             field_name [4] = '{"quat_w", "quat_x", "quat_y", "quat_z"};

  function automatic quat_t advance_attitude(quat_t cur, logic [RATE_W-1:0] rx,
                                             logic [RATE_W-1:0] ry, logic [RATE_W-1:0] rz);
    longint          wx, wy, wz, t;
    longint          qa [4];
    longint          dq [4];
    longint          p [4];
    longint          v [4];
    longint unsigned mag [4];
    longint unsigned peak, m, sumsq, root, cand;
    int              shift;
    quat_t           nxt;
    for (int i = 0; i < 4; i++) qa[i] = longint'($signed(cur[i]));
    wx = longint'($signed(rx)) - longint'($signed(gyro_bias[0]));
    wy = longint'($signed(ry)) - longint'($signed(gyro_bias[1]));
    wz = longint'($signed(rz)) - longint'($signed(gyro_bias[2]));
    dq[0] = -(wx * qa[1] + wy * qa[2] + wz * qa[3]);
    dq[1] = wx * qa[0] + wz * qa[2] - wy * qa[3];
    dq[2] = wy * qa[0] - wz * qa[1] + wx * qa[3];
    dq[3] = wz * qa[0] + wy * qa[1] - wx * qa[2];
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      // half, dt and q46 to q30 in one floor step after the first floor
      t = dq[i] >>> 18;
      p[i] = qa[i] + ((t * longint'(step_len)) >>> 23);
      mag[i] = (p[i] < 0) ? -p[i] : p[i];
      if (mag[i] > peak) peak = mag[i];
    end
    shift = 0;
    while ((peak >> shift) > 64'h7FFF_FFFF) shift++;
    sumsq = 0;
    for (int i = 0; i < 4; i++) begin
      m = mag[i] >> shift;
      v[i] = (p[i] < 0) ? -longint'(m) : longint'(m);
      sumsq += m * m;
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= sumsq) root = cand;
    end
    // zero norm keeps the previous attitude
    if (root == 0) return cur;
    for (int i = 0; i < 4; i++) nxt[i] = Q_W'((v[i] <<< 30) / longint'(root));
    return nxt;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_len     = STEP_TIME_RST;
      gyro_bias[0] = '0;
      gyro_bias[1] = '0;
      gyro_bias[2] = '0;
      start_quat   = '0;
      start_quat[0] = ONE_Q30;
      attitude     = start_quat;
      expected_quats.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_STEP_TIME: step_len      = cfg_wdata[STEP_W-1:0];
          REG_BIAS_X:    gyro_bias[0]  = cfg_wdata[RATE_W-1:0];
          REG_BIAS_Y:    gyro_bias[1]  = cfg_wdata[RATE_W-1:0];
          REG_BIAS_Z:    gyro_bias[2]  = cfg_wdata[RATE_W-1:0];
          REG_START_W:   start_quat[0] = cfg_wdata;
          REG_START_X:   start_quat[1] = cfg_wdata;
          REG_START_Y:   start_quat[2] = cfg_wdata;
          REG_START_Z:   start_quat[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0]) attitude = start_quat;
        else attitude = advance_attitude(attitude, in_tdata[RATE_W-1:0],
                                         in_tdata[2*RATE_W-1:RATE_W],
                                         in_tdata[3*RATE_W-1:2*RATE_W]);
        expected_quats.push_back(attitude);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_quats.size() == 0) begin
          note_mismatch($sformatf("result with no item pending: %h", out_tdata));
        end else begin
          want = expected_quats.pop_front();
          for (int i = 0; i < 4; i++)
            if (got[i] !== want[i])
              note_mismatch($sformatf("%s mismatch: expected %0d got %0d", field_name[i],
                                      $signed(want[i]), $signed(got[i])));
        end
      end
      outstanding <= expected_quats.size();
    end
  end

endmodule

/* sim/tb_quaternion_attitude_integrator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion attitude integrator testbench
// directed gyro samples, loads and register extremes, then random phases
// under bursty input and a stalling receiver; the checker judges the results
// ----------------------------------------------------------------------------
module tb_quaternion_attitude_integrator;
  import qai_pkg::*;

  localparam bit              MODE_INTEGRATE = 1'b0;
  localparam bit              MODE_LOAD      = 1'b1;
  localparam logic [RATE_W-1:0] RATE_MAX     = 24'h7F_FFFF;
  localparam logic [RATE_W-1:0] RATE_MIN     = 24'h80_0000;
  localparam int              HOLD_AT        = 350;
  localparam int              HOLD_CYCLES    = 3000;

  typedef enum int {RX_OPEN, RX_SHUT, RX_JITTER, RX_BRIEF} rx_style_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  int                    mismatch_count;
  int                    pending_results;
  int                    burst_left = 0;

  quaternion_attitude_integrator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  quaternion_attitude_integrator_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatch_count),
    .outstanding (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic write_reg(qai_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(bit mode, logic [RATE_W-1:0] rx, logic [RATE_W-1:0] ry,
                           logic [RATE_W-1:0] rz);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(41, 300);
        1, 2, 3: gap = $urandom_range(6, 40);
        default: gap = $urandom_range(0, 5);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {rz, ry, rx};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // wait until every result is back and the block is idle
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [RATE_W-1:0] random_rate();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return RATE_W'($urandom);
      4, 5, 6, 7: return RATE_W'(int'($urandom_range(0, 131072)) - 65536);
      8:          return $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
      default:    return '0;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_start(int style);
    case (style)
      1:       return '0;
      2:       return $urandom;
      default: return CFG_DATA_W'(int'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  // receiver: random stall pattern with one long hold-off
  initial begin : receiver
    int        left;
    int        delivered;
    bit        held;
    rx_style_t style;
    left      = 0;
    delivered = 0;
    held      = 1'b0;
    style     = RX_OPEN;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) delivered++;
      if (!held && delivered >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = rx_style_t'($urandom_range(0, 3));
          left  = (style == RX_OPEN) ? $urandom_range(1, 400) : $urandom_range(1, 150);
        end
        left--;
        case (style)
          RX_SHUT:   out_tready <= 1'b0;
          RX_JITTER: out_tready <= $urandom_range(0, 1);
          default:   out_tready <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    int style;
    logic [CFG_DATA_W-1:0] step;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: identity, zero rate, rate extremes, load
    send_item(MODE_INTEGRATE, '0, '0, '0);
    send_item(MODE_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX);
    send_item(MODE_INTEGRATE, RATE_MIN, RATE_MIN, RATE_MIN);
    send_item(MODE_INTEGRATE, RATE_MAX, RATE_MIN, '0);
    send_item(MODE_LOAD, 24'h5A5A5A, 24'hA5A5A5, 24'hFFFFFF);
    send_item(MODE_INTEGRATE, 24'h000100, 24'hFFFF00, 24'h010000);
    settle();

    // longest step and bias extremes
    write_reg(REG_STEP_TIME, 32'h00FF_FFFF);
    write_reg(REG_BIAS_X, 32'h0080_0000);
    write_reg(REG_BIAS_Y, 32'h007F_FFFF);
    write_reg(REG_BIAS_Z, 32'hFF12_3456);
    send_item(MODE_INTEGRATE, RATE_MAX, RATE_MIN, RATE_MAX);
    send_item(MODE_INTEGRATE, RATE_MIN, RATE_MAX, RATE_MIN);
    send_item(MODE_INTEGRATE, '0, '0, '0);
    settle();

    // step time zero after loading an unnormalized quaternion
    write_reg(REG_STEP_TIME, 32'h0);
    write_reg(REG_START_W, 32'h7FFF_FFFF);
    write_reg(REG_START_X, 32'h8000_0000);
    write_reg(REG_START_Y, 32'h7FFF_FFFF);
    write_reg(REG_START_Z, 32'h8000_0000);
    send_item(MODE_LOAD, RATE_MAX, RATE_MAX, RATE_MAX);
    send_item(MODE_INTEGRATE, random_rate(), random_rate(), random_rate());
    send_item(MODE_INTEGRATE, random_rate(), random_rate(), random_rate());
    settle();

    // zero quaternion gives zero norm
    write_reg(REG_STEP_TIME, 32'h1);
    write_reg(REG_START_W, 32'h0);
    write_reg(REG_START_X, 32'h0);
    write_reg(REG_START_Y, 32'h0);
    write_reg(REG_START_Z, 32'h0);
    send_item(MODE_LOAD, '0, '0, '0);
    send_item(MODE_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX);
    send_item(MODE_INTEGRATE, RATE_MIN, RATE_MAX, RATE_MIN);
    settle();

    // negative unit scalar with fast rotation
    write_reg(REG_STEP_TIME, 32'h00FF_FFFF);
    write_reg(REG_BIAS_X, 32'h0);
    write_reg(REG_BIAS_Y, 32'h0);
    write_reg(REG_BIAS_Z, 32'h0);
    write_reg(REG_START_W, 32'hC000_0000);
    write_reg(REG_START_X, 32'h4000_0000);
    send_item(MODE_LOAD, '0, '0, '0);
    send_item(MODE_INTEGRATE, RATE_MAX, RATE_MAX, RATE_MAX);
    send_item(MODE_INTEGRATE, 24'h010000, RATE_MIN, 24'h7F0000);
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case ($urandom_range(0, 4))
        0:       step = 32'h1;
        1:       step = 32'h00FF_FFFF;
        2:       step = $urandom;
        3:       step = $urandom_range(1, 262144);
        default: step = STEP_TIME_RST;
      endcase
      write_reg(REG_STEP_TIME, step);
      for (int a = 0; a < 3; a++) begin
        case ($urandom_range(0, 2))
          0:       write_reg(qai_reg_t'(REG_BIAS_X + a), 32'h0);
          1:       write_reg(qai_reg_t'(REG_BIAS_X + a), $urandom);
          default: write_reg(qai_reg_t'(REG_BIAS_X + a),
                             CFG_DATA_W'(int'($urandom_range(0, 8192)) - 4096));
        endcase
      end
      style = $urandom_range(0, 7);
      for (int j = 0; j < 4; j++) begin
        if (style == 0)
          write_reg(qai_reg_t'(REG_START_W + j), (j == 0) ? CFG_DATA_W'(ONE_Q30) : '0);
        else
          write_reg(qai_reg_t'(REG_START_W + j), random_start((style == 1) ? 1 :
                                                              (style < 4) ? 2 : 3));
      end
      for (int i = 0; i < 200; i++)
        send_item(($urandom_range(0, 15) == 0) ? MODE_LOAD : MODE_INTEGRATE,
                  random_rate(), random_rate(), random_rate());
      settle();
    end

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
